[rtl/utf8_stream_validator_defines.svh]
// Assertion macros shared by the UTF-8 stream validator RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef UTF8_STREAM_VALIDATOR_DEFINES_SVH
`define UTF8_STREAM_VALIDATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define U8SV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("u8sv assertion failed");

// Next-cycle implication, checked outside reset.
`define U8SV_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("u8sv assertion failed");

`endif

[rtl/u8sv_pkg.sv]
// Shared types and constants of the UTF-8 stream validator.
// No dependencies; used by u8sv_step and utf8_stream_validator.
`default_nettype none

package u8sv_pkg;

  localparam int CODE_W = 21;

  // Prefix tags of lead and continuation bytes.
  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;

  // Length codes of the open sequence (counted in continuation bytes).
  localparam logic [1:0] SEQ_NONE  = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  // Highest overlong value for each sequence length.
  localparam logic [CODE_W-1:0] FLOOR_TWO   = 21'h00007F;
  localparam logic [CODE_W-1:0] FLOOR_THREE = 21'h0007FF;
  localparam logic [CODE_W-1:0] FLOOR_FOUR  = 21'h00FFFF;

  typedef struct packed {
    logic [1:0]        bytes_pending;
    logic [1:0]        seq_length;
    logic [CODE_W-1:0] partial_code;
    logic              error_latched;
  } dec_state_t;

  localparam dec_state_t STATE_CLEAR = '{
    bytes_pending: 2'd0,
    seq_length:    SEQ_NONE,
    partial_code:  '0,
    error_latched: 1'b0
  };

endpackage

`default_nettype wire

[rtl/u8sv_step.sv]
// Per-byte decode step: next decoder state and verdict for one byte.
// Depends on u8sv_pkg.
`default_nettype none

module u8sv_step (
  input  u8sv_pkg::dec_state_t state_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output u8sv_pkg::dec_state_t state_o,
  output logic                 verdict_o
);
  import u8sv_pkg::*;

  dec_state_t        upd;
  logic [CODE_W-1:0] shifted;
  logic [CODE_W-1:0] floor_value;

  assign shifted = {state_i.partial_code[CODE_W-7:0], byte_i[5:0]};

  always_comb begin
    case (state_i.seq_length)
      SEQ_TWO:   floor_value = FLOOR_TWO;
      SEQ_THREE: floor_value = FLOOR_THREE;
      default:   floor_value = FLOOR_FOUR;
    endcase
  end

  always_comb begin
    upd = state_i;
    if (!state_i.error_latched) begin
      if (state_i.bytes_pending != 2'd0) begin
        // Expecting a continuation byte.
        if (byte_i[7:6] != CONT_TAG) begin
          upd.error_latched = 1'b1;
        end else begin
          upd.bytes_pending = state_i.bytes_pending - 2'd1;
          upd.partial_code  = shifted;
          if (state_i.bytes_pending == 2'd1) begin
            if (shifted <= floor_value) begin
              upd.error_latched = 1'b1;
            end
            upd.seq_length   = SEQ_NONE;
            upd.partial_code = '0;
          end
        end
      end else if (byte_i[7] == 1'b0) begin
        // Single-byte character: nothing to track.
      end else if (byte_i[7:5] == LEAD2_TAG) begin
        upd.partial_code  = CODE_W'(byte_i[4:0]);
        upd.seq_length    = SEQ_TWO;
        upd.bytes_pending = 2'd1;
      end else if (byte_i[7:4] == LEAD3_TAG) begin
        upd.partial_code  = CODE_W'(byte_i[3:0]);
        upd.seq_length    = SEQ_THREE;
        upd.bytes_pending = 2'd2;
      end else if (byte_i[7:3] == LEAD4_TAG) begin
        upd.partial_code  = CODE_W'(byte_i[2:0]);
        upd.seq_length    = SEQ_FOUR;
        upd.bytes_pending = 2'd3;
      end else begin
        // Stray continuation or a lead byte of F8 to FF.
        upd.error_latched = 1'b1;
      end
    end
  end

  // A cut-off sequence at the end of the string makes the verdict invalid.
  assign verdict_o = !upd.error_latched && (upd.bytes_pending == 2'd0);
  assign state_o   = last_i ? STATE_CLEAR : upd;

endmodule

`default_nettype wire

[rtl/utf8_stream_validator.sv]
// Top level of the UTF-8 stream validator: input register, decode step, result register.
// Depends on u8sv_pkg, u8sv_step and utf8_stream_validator_defines.svh.
//
//  Channel | Direction | tdata (low bit up)      | tuser | tlast
//  --------+-----------+-------------------------+-------+-----------------
//  in_     | slave     | [7:0] byte_value        | none  | last_byte
//  out_    | master    | [0] utf8_valid, 0 above | none  | none
//
// One byte is taken per cycle unless the input register stalls. A request is decoded
// while it sits in the input register and its verdict is written to the result register
// when it leaves, so out_tvalid rises once the last byte has left the input register.
// Reset (rst_n low, synchronous) empties both registers and clears the decoder
// state. Only a request carrying tlast needs the result register; when that
// register still holds an untaken verdict such a request stalls in the input
// register, otherwise bytes keep flowing.
`default_nettype none

`include "utf8_stream_validator_defines.svh"

module utf8_stream_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] utf8_valid, [7:1] zero
);
  import u8sv_pkg::*;

  // Input register.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Decoder state, carried from string byte to string byte.
  dec_state_t state_r, state_nxt;
  dec_state_t step_state;
  logic       step_verdict;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  logic out_bit_r;

  logic s1_go;
  logic in_take;

  // The held byte moves on unless it needs the result register and that
  // register is full and not being drained.
  assign s1_go   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_take = in_tvalid && in_tready;

  u8sv_step u_step (
    .state_i   (state_r),
    .byte_i    (s1_byte_r),
    .last_i    (s1_last_r),
    .state_o   (step_state),
    .verdict_o (step_verdict)
  );

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);
    state_nxt    = s1_go ? step_state : state_r;
    if (s1_go && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= STATE_CLEAR;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_go && s1_last_r) begin
      out_bit_r <= step_verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

  // Pending continuation bytes never exceed the length of the open sequence.
  `U8SV_ASSERT_IMP(a_pending_le_len, clk, rst_n, 1'b1, state_r.bytes_pending <= state_r.seq_length)
  // With no sequence open, no partial value is kept.
  `U8SV_ASSERT_IMP(a_idle_code_zero, clk, rst_n, state_r.bytes_pending == 2'd0, state_r.partial_code == '0)
  // The end of a string leaves the decoder cleared.
  `U8SV_ASSERT_NXT(a_clear_after_last, clk, rst_n, s1_go && s1_last_r, state_r == STATE_CLEAR)
  // A verdict only appears right after a last byte was decoded.
  `U8SV_ASSERT_IMP(a_verdict_source, clk, rst_n, $rose(out_valid_r), $past(s1_go && s1_last_r))

endmodule

`default_nettype wire

[test/tb_utf8_stream_validator.sv]
// Self-checking testbench for utf8_stream_validator: sends byte strings with tlast
// and checks each verdict against a cycle-free decoder kept in the bench.
// Depends on u8sv_pkg and the utf8_stream_validator RTL.

module tb_utf8_stream_validator;
  import u8sv_pkg::*;

  // A pending byte request: one raw byte and its end-of-string flag.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_req_t;

  // Kinds of character the random generator writes into a string.
  typedef enum int {
    CH_WELL_FORMED,
    CH_OVERLONG,
    CH_STRAY_CONT,
    CH_BAD_LEAD,
    CH_CUT_SHORT,
    CH_NOISE
  } char_kind_e;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_BYTES = 400;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] byte_value
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] utf8_valid, [7:1] zero

  // Bytes waiting for the driver, the string under construction, and the
  // verdicts the decoder model has worked out but the block has not yet given.
  byte_req_t  byte_q[$];
  logic [7:0] str_q[$];
  logic       verdict_q[$];

  // Decoder model state, advanced once per accepted byte request.
  dec_state_t model_st = STATE_CLEAR;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  utf8_stream_validator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Advance the decoder model by one byte. A byte with the last flag closes
  // the string: its verdict is queued and the model returns to the clear state.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    logic [CODE_W-1:0] overlong_max;
    if (!model_st.error_latched) begin
      if (model_st.bytes_pending != 2'd0) begin
        // A continuation is due; anything else is a missing continuation and
        // is not looked at again as a lead byte.
        if (b[7:6] != CONT_TAG) begin
          model_st.error_latched = 1'b1;
        end else begin
          model_st.partial_code = {model_st.partial_code[CODE_W-7:0], b[5:0]};
          model_st.bytes_pending = model_st.bytes_pending - 2'd1;
          if (model_st.bytes_pending == 2'd0) begin
            case (model_st.seq_length)
              SEQ_TWO:   overlong_max = FLOOR_TWO;
              SEQ_THREE: overlong_max = FLOOR_THREE;
              default:   overlong_max = FLOOR_FOUR;
            endcase
            if (model_st.partial_code <= overlong_max) model_st.error_latched = 1'b1;
            model_st.seq_length = SEQ_NONE;
            model_st.partial_code = '0;
          end
        end
      end else if (!b[7]) begin
        // Plain ASCII, nothing opens.
      end else if (b[7:5] == LEAD2_TAG) begin
        model_st.partial_code = CODE_W'(b[4:0]);
        model_st.seq_length = SEQ_TWO;
        model_st.bytes_pending = 2'd1;
      end else if (b[7:4] == LEAD3_TAG) begin
        model_st.partial_code = CODE_W'(b[3:0]);
        model_st.seq_length = SEQ_THREE;
        model_st.bytes_pending = 2'd2;
      end else if (b[7:3] == LEAD4_TAG) begin
        model_st.partial_code = CODE_W'(b[2:0]);
        model_st.seq_length = SEQ_FOUR;
        model_st.bytes_pending = 2'd3;
      end else begin
        // Stray continuation or a lead byte of F8 to FF.
        model_st.error_latched = 1'b1;
      end
    end
    if (last) begin
      verdict_q.push_back(!model_st.error_latched && model_st.bytes_pending == 2'd0);
      model_st = STATE_CLEAR;
    end
  endtask

  // Append one code point to the string in len bytes, overlong or not.
  task automatic encode_char(input logic [20:0] v, input int len);
    case (len)
      1: str_q.push_back({1'b0, v[6:0]});
      2: begin
        str_q.push_back({LEAD2_TAG, v[10:6]});
        str_q.push_back({CONT_TAG, v[5:0]});
      end
      3: begin
        str_q.push_back({LEAD3_TAG, v[15:12]});
        str_q.push_back({CONT_TAG, v[11:6]});
        str_q.push_back({CONT_TAG, v[5:0]});
      end
      default: begin
        str_q.push_back({LEAD4_TAG, v[20:18]});
        str_q.push_back({CONT_TAG, v[17:12]});
        str_q.push_back({CONT_TAG, v[11:6]});
        str_q.push_back({CONT_TAG, v[5:0]});
      end
    endcase
  endtask

  // Move the finished string into the driver queue, flagging its final byte.
  task automatic flush_string();
    byte_req_t req;
    while (str_q.size() > 0) begin
      req.data = str_q.pop_front();
      req.last = (str_q.size() == 0);
      byte_q.push_back(req);
    end
  endtask

  // Queue a hand-written string of n bytes, packed first byte highest.
  task automatic directed(input logic [31:0] bytes, input int n);
    for (int i = n - 1; i >= 0; i--) str_q.push_back(bytes[8*i +: 8]);
    flush_string();
  endtask

  // Build one random string. Half the strings are entirely well formed; the
  // rest mix in overlong forms, stray continuations, bad lead bytes,
  // sequences cut short (possibly by the end of the string) and raw noise.
  task automatic random_string(output int n_bytes);
    int n_chars;
    int len;
    int cut;
    bit clean;
    char_kind_e kind;
    logic [20:0] v;
    n_chars = $urandom_range(6, 1);
    clean = 1'($urandom_range(1, 0));
    for (int i = 0; i < n_chars; i++) begin
      if (clean || $urandom_range(99) < 70) kind = CH_WELL_FORMED;
      else kind = char_kind_e'($urandom_range(CH_NOISE, CH_OVERLONG));
      len = $urandom_range(4, 1);
      case (kind)
        CH_WELL_FORMED: begin
          case (len)
            1: v = 21'($urandom_range(21'h7F, 0));
            2: v = 21'($urandom_range(21'h7FF, 21'h80));
            3: v = 21'($urandom_range(21'hFFFF, 21'h800));
            default: v = 21'($urandom_range(21'h1FFFFF, 21'h10000));
          endcase
          encode_char(v, len);
        end
        CH_OVERLONG: begin
          len = $urandom_range(4, 2);
          case (len)
            2: v = FLOOR_TWO;
            3: v = FLOOR_THREE;
            default: v = FLOOR_FOUR;
          endcase
          // Half the time the highest overlong value, the edge of the check.
          if ($urandom_range(1, 0)) v = 21'($urandom_range(v, 0));
          encode_char(v, len);
        end
        CH_STRAY_CONT: str_q.push_back({CONT_TAG, 6'($urandom_range(63, 0))});
        CH_BAD_LEAD:   str_q.push_back(8'($urandom_range(8'hFF, 8'hF8)));
        CH_CUT_SHORT: begin
          len = $urandom_range(4, 2);
          encode_char(21'($urandom_range(21'h1FFFFF, 0)), len);
          cut = $urandom_range(len - 1, 1);
          repeat (cut) void'(str_q.pop_back());
        end
        default: str_q.push_back(8'($urandom));
      endcase
    end
    n_bytes = str_q.size();
    flush_string();
  endtask

  // Queue random strings until about n bytes are waiting.
  task automatic random_bytes(input int n);
    int total;
    int got;
    total = 0;
    while (total < n) begin
      random_string(got);
      total += got;
    end
  endtask

  // Hold the sender back until every queued request has been taken and every
  // verdict has come out, then let the pipeline settle.
  task automatic drain();
    while (byte_q.size() != 0 || in_tvalid || verdict_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Driver: a new request goes out when the line is empty or the current
  // request was just taken. Each signal gets one assignment per edge.
  always @(posedge clk) begin
    byte_req_t req;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req = byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= req.data;
        in_tlast <= req.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every accepted byte request advances the decoder model.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
  end

  // Verdict checker: each accepted result is matched with the oldest verdict.
  always @(posedge clk) begin
    logic exp_valid;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected verdict: utf8_valid got %0d (tdata %02h)",
                   $time, out_tdata[0], out_tdata);
      end else begin
        exp_valid = verdict_q.pop_front();
        if (out_tdata !== {7'd0, exp_valid}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] verdict mismatch: utf8_valid exp %0d got tdata %02h",
                     $time, exp_valid, out_tdata);
        end
      end
    end
  end

  // Watchdog: too long without any request taken on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog expired after %0d idle cycles", stall_cycles);
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed strings: edges of each sequence length and each error kind.
    send_idle_pct = 11;
    recv_idle_pct = 45;
    directed(32'h00, 1);              // lowest ASCII byte
    directed(32'h7F, 1);              // highest ASCII byte
    directed(32'hC280, 2);            // smallest two-byte value
    directed(32'hC1BF, 2);            // overlong two-byte form
    directed(32'h80, 1);              // stray continuation
    directed(32'hF8, 1);              // bad lead byte, low end
    directed(32'hFF, 1);              // bad lead byte, high end
    directed(32'hE041, 2);            // missing continuation
    directed(32'hE282, 2);            // cut short by the end of the string
    directed(32'hF48FBFBF, 4);        // highest Unicode scalar value
    directed(32'hEFBFBF, 3);          // largest three-byte value
    directed(32'hF08FBFBF, 4);        // overlong four-byte form

    // Phase one: sender idles lightly, receiver heavily. Halfway through the
    // sender waits for every verdict before going on.
    random_bytes(PHASE_BYTES / 2);
    drain();
    random_bytes(PHASE_BYTES / 2);
    drain();

    // Phase two: the other way round.
    send_idle_pct = 45;
    recv_idle_pct = 11;
    random_bytes(PHASE_BYTES);
    drain();

    // Phase three: both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_bytes(PHASE_BYTES);
    drain();

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
